FILE: hdl/lsf_pkg.sv
// Shared types and constants for the LSB stego frame extractor.
`timescale 1ns / 1ps

package lsf_pkg;

  localparam int unsigned HeaderBytes = 54;
  localparam int unsigned LenBits     = 32;
  localparam int unsigned ByteBits    = 8;
  localparam int unsigned MagicMax    = 8;

  localparam logic [63:0] MagicWordRst = 64'h0000_0000_0000_2A23;
  localparam logic [3:0]  MagicLenRst  = 4'd2;

  // register indexes
  localparam logic CfgMagicWord = 1'b0;
  localparam logic CfgMagicLen  = 1'b1;

  // result kinds
  localparam logic [2:0] KindMismatch = 3'd0;
  localparam logic [2:0] KindExtLen   = 3'd1;
  localparam logic [2:0] KindExtByte  = 3'd2;
  localparam logic [2:0] KindPayLen   = 3'd3;
  localparam logic [2:0] KindPayByte  = 3'd4;

  typedef enum logic [6:0] {
    PH_IDLE    = 7'b000_0001,
    PH_HEADER  = 7'b000_0010,
    PH_MAGIC   = 7'b000_0100,
    PH_EXTLEN  = 7'b000_1000,
    PH_EXTDATA = 7'b001_0000,
    PH_PAYLEN  = 7'b010_0000,
    PH_PAYDATA = 7'b100_0000
  } lsf_phase_e;

  typedef struct packed {
    logic [63:0] magic_word;
    logic [3:0]  magic_len;
  } lsf_cfg_t;

  typedef struct packed {
    logic        valid;
    logic [2:0]  kind;
    logic [31:0] value;
    logic        last;
  } lsf_res_t;

endpackage

FILE: hdl/lsf_parser.sv
// Frame parser: header skip, LSB gathering, magic check and length tracking.
`timescale 1ns / 1ps

module lsf_parser import lsf_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     step_i,
  input  logic     bit_i,
  input  logic     start_i,
  input  lsf_cfg_t cfg_i,
  output lsf_res_t res_o
);

  lsf_phase_e  phase_q, phase_d;
  logic [5:0]  hc_q, hc_d;
  logic [4:0]  bc_q, bc_d;
  logic [31:0] gs_q, gs_d;
  logic [2:0]  mi_q, mi_d;
  logic [31:0] rem_q, rem_d;

  always_comb begin
    lsf_phase_e  ph;
    logic [5:0]  hc, hc_inc;
    logic [4:0]  bc;
    logic [31:0] gs, word, rem, rem_dec;
    logic [2:0]  mi;
    logic [3:0]  mlen, mi_inc;
    logic [7:0]  expect_byte;
    logic        is_len, done;

    ph  = start_i ? PH_HEADER : phase_q;
    hc  = start_i ? '0 : hc_q;
    bc  = start_i ? '0 : bc_q;
    gs  = start_i ? '0 : gs_q;
    mi  = start_i ? '0 : mi_q;
    rem = start_i ? '0 : rem_q;

    hc_inc  = hc + 6'd1;
    word    = gs | (32'(bit_i) << bc);
    is_len  = (ph == PH_EXTLEN) || (ph == PH_PAYLEN);
    done    = is_len ? (bc == 5'(LenBits - 1)) : (bc == 5'(ByteBits - 1));
    rem_dec = rem - 32'd1;
    mi_inc  = {1'b0, mi} + 4'd1;

    mlen = cfg_i.magic_len;
    if (mlen == 4'd0) mlen = 4'd1;
    if (mlen > 4'(MagicMax)) mlen = 4'(MagicMax);
    expect_byte = cfg_i.magic_word[{mi, 3'b000} +: 8];

    phase_d = ph;
    hc_d    = hc;
    bc_d    = bc;
    gs_d    = gs;
    mi_d    = mi;
    rem_d   = rem;
    res_o   = '0;

    unique case (ph)
      PH_HEADER: begin
        hc_d = hc_inc;
        if (hc_inc >= 6'(HeaderBytes)) begin
          phase_d = PH_MAGIC;
          bc_d    = '0;
          gs_d    = '0;
          mi_d    = '0;
        end
      end
      PH_MAGIC, PH_EXTLEN, PH_EXTDATA, PH_PAYLEN, PH_PAYDATA: begin
        if (!done) begin
          bc_d = bc + 5'd1;
          gs_d = word;
        end else begin
          bc_d = '0;
          gs_d = '0;
          unique case (ph)
            PH_MAGIC: begin
              if (word[7:0] != expect_byte) begin
                phase_d   = PH_IDLE;
                mi_d      = '0;
                res_o     = '{valid: 1'b1, kind: KindMismatch, value: '0, last: 1'b1};
              end else if (mi_inc >= mlen) begin
                mi_d    = '0;
                phase_d = PH_EXTLEN;
              end else begin
                mi_d = mi_inc[2:0];
              end
            end
            PH_EXTLEN: begin
              rem_d   = word;
              phase_d = (word == '0) ? PH_PAYLEN : PH_EXTDATA;
              res_o   = '{valid: 1'b1, kind: KindExtLen, value: word, last: 1'b0};
            end
            PH_EXTDATA: begin
              rem_d = rem_dec;
              if (rem_dec == '0) phase_d = PH_PAYLEN;
              res_o = '{valid: 1'b1, kind: KindExtByte, value: {24'd0, word[7:0]},
                        last: 1'b0};
            end
            PH_PAYLEN: begin
              rem_d   = word;
              phase_d = (word == '0) ? PH_IDLE : PH_PAYDATA;
              res_o   = '{valid: 1'b1, kind: KindPayLen, value: word, last: (word == '0)};
            end
            default: begin
              rem_d = rem_dec;
              if (rem_dec == '0) phase_d = PH_IDLE;
              res_o = '{valid: 1'b1, kind: KindPayByte, value: {24'd0, word[7:0]},
                        last: (rem_dec == '0)};
            end
          endcase
        end
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      hc_q    <= '0;
      bc_q    <= '0;
      gs_q    <= '0;
      mi_q    <= '0;
      rem_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      hc_q    <= hc_d;
      bc_q    <= bc_d;
      gs_q    <= gs_d;
      mi_q    <= mi_d;
      rem_q   <= rem_d;
    end
  end

  // data phases hold a bit count below the field width
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_MAGIC || phase_q == PH_EXTDATA || phase_q == PH_PAYDATA)
      |-> (bc_q < 5'(ByteBits)))
    else $error("byte phase bit count overflow");

  // extension and payload data phases never sit with nothing left to read
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_EXTDATA || phase_q == PH_PAYDATA) |-> (rem_q != '0))
    else $error("data phase with zero remaining");

  // header count only advances while in the header phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && !start_i && phase_q != PH_HEADER) |=> $stable(hc_q))
    else $error("header count moved outside header");

endmodule

FILE: hdl/lsb_stego_frame_extractor.sv
// Top level of the LSB stego frame extractor: input stage, config, result register.
//
//  channel  | dir | tdata                 | tuser           | tlast
//  s_axis   | in  | [7:0] cover_byte      | [0] frame_start | -
//  m_axis   | out | [31:0] value          | [2:0] kind      | last
//  cfg      | in  | cfg_wdata_i, cfg_idx_i selects register, cfg_we_i writes
//
// One word per cycle sustained unless a result meets a full, stalled result register.
// The input register feeds the parser and the result register in one pass.
// A word that gives no result drains even while the result register is full.
// Reset clears the parser to idle and loads magic 0x2A23, magic length 2.
`timescale 1ns / 1ps

module lsb_stego_frame_extractor import lsf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] cover_byte
  input  logic        s_axis_tuser_i,   // [0] frame_start
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // [31:0] value
  output logic [2:0]  m_axis_tuser_o,   // [2:0] kind
  output logic        m_axis_tlast_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [63:0] cfg_wdata_i
);

  lsf_cfg_t    cfg_q;
  logic        in_valid_q;
  logic        in_bit_q;
  logic        in_start_q;
  lsf_res_t    res;
  logic        advance;
  logic        load;
  logic        out_valid_q;
  logic [2:0]  out_kind_q;
  logic [31:0] out_value_q;
  logic        out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic_word <= MagicWordRst;
      cfg_q.magic_len  <= MagicLenRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgMagicWord: cfg_q.magic_word <= cfg_wdata_i;
        CfgMagicLen:  cfg_q.magic_len  <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  assign advance         = in_valid_q && (!res.valid || !out_valid_q || m_axis_tready_i);
  assign load            = advance && res.valid;
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_bit_q   <= s_axis_tdata_i[0];
      in_start_q <= s_axis_tuser_i;
    end
  end

  lsf_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (advance),
    .bit_i   (in_bit_q),
    .start_i (in_start_q),
    .cfg_i   (cfg_q),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_kind_q  <= res.kind;
      out_value_q <= res.value;
      out_last_q  <= res.last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_value_q;
  assign m_axis_tuser_o  = out_kind_q;
  assign m_axis_tlast_o  = out_last_q;

  // a new result only lands in a free or draining slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> (!out_valid_q || m_axis_tready_i))
    else $error("result overwritten before taken");

  // a held input word blocks the slave side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |-> !s_axis_tready_o)
    else $error("input accepted while stage stalled");

  // mismatch always ends the frame with a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_kind_q == KindMismatch) |-> (out_last_q && out_value_q == '0))
    else $error("bad mismatch result");

  // extension results never end a frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_kind_q == KindExtLen || out_kind_q == KindExtByte))
      |-> !out_last_q)
    else $error("extension result marked last");

endmodule
